[hw/rtl/ple_pkg.sv]
// Shared types and constants for the positional list engine.
// Depends on nothing; every other file in hw/rtl imports it.
package ple_pkg;

    // Sizing of the element store and the fields
    localparam int CAPACITY    = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DATA_W      = 32;
    localparam int POS_W       = 8;
    localparam int CMP_W       = POS_W + 1;
    localparam int FPOS_W      = 7;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 3;

    // Command queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_INS_FRONT = 3'd0,
        KIND_INS_BACK  = 3'd1,
        KIND_INS_AT    = 3'd2,
        KIND_DEL_FRONT = 3'd3,
        KIND_DEL_BACK  = 3'd4,
        KIND_DEL_AT    = 3'd5,
        KIND_SEARCH    = 3'd6,
        KIND_LIST_ALL  = 3'd7
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_RANGE    = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    // Decoded command as it travels through the queue
    typedef struct packed {
        kind_t              kind;
        logic               is_insert;
        logic               is_delete;
        logic               pos_zero;
        logic [DATA_W-1:0]  value;
        logic [POS_W-1:0]   position;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_SEARCH,
        BK_LIST
    } back_state_t;

endpackage

[hw/rtl/ple_front.sv]
// Front of the positional list engine: takes input beats and decodes them.
// Depends on ple_pkg.
module ple_front import ple_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [KIND_W-1:0]        kind,
    input  logic signed [DATA_W-1:0] value,
    input  logic [POS_W-1:0]         position,
    output logic                     cmd_valid,
    input  logic                     cmd_stall,
    output cmd_t                     cmd
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    cmd_t decoded;
    logic load;

    // Classify the incoming beat
    always_comb
    begin
        decoded          = '0;
        decoded.kind     = kind_t'(kind);
        decoded.value    = value;
        decoded.position = position;
        decoded.pos_zero = (position == '0);
        unique case (kind_t'(kind))
            KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT:
            begin
                decoded.is_insert = 1'b1;
            end
            KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AT:
            begin
                decoded.is_delete = 1'b1;
            end
            KIND_SEARCH, KIND_LIST_ALL:
            begin
                decoded.is_insert = 1'b0;
            end
        endcase
    end

    // Hold the decoded beat until the queue takes it
    assign load     = !hold_valid_reg || !cmd_stall;
    assign in_stall = !load;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        cmd_next        = cmd_reg;
        if (load)
        begin
            hold_valid_next = in_valid;
            if (in_valid)
            begin
                cmd_next = decoded;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = hold_valid_reg;
    assign cmd       = cmd_reg;

endmodule

[hw/rtl/ple_queue.sv]
// Short command queue between the front and the back of the list engine.
// Depends on ple_pkg.
module ple_queue import ple_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_stall,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_stall,
    output cmd_t pop_data
);

    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    cmd_t              slots_reg [QUEUE_DEPTH];
    logic              push;
    logic              pop;

    assign push_stall = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;
    assign pop_data   = slots_reg[rd_ptr_reg];

    // Advance pointers and the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + (QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/ple_back.sv]
// Back of the positional list engine: element store, command execution
// and the output register. Depends on ple_pkg.
module ple_back import ple_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  cmd_t                     cmd,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic signed [DATA_W-1:0] result_value,
    output logic [FPOS_W-1:0]        found_position,
    output logic                     last,
    output logic [CNT_W-1:0]         cnt
);

    back_state_t       state_reg;
    back_state_t       state_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [DATA_W-1:0] entries_reg  [CAPACITY];
    logic [DATA_W-1:0] entries_next [CAPACITY];
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] match_next;
    logic [IDX_W-1:0]  list_idx_reg;
    logic [IDX_W-1:0]  list_idx_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           out_status_reg;
    status_t           out_status_next;
    logic [DATA_W-1:0] out_value_reg;
    logic [DATA_W-1:0] out_value_next;
    logic [FPOS_W-1:0] out_fpos_reg;
    logic [FPOS_W-1:0] out_fpos_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic              out_free;
    logic              is_full;
    logic              is_empty;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  pos_ext;
    status_t           ins_status;
    logic [CMP_W-1:0]  ins_idx;
    status_t           del_status;
    logic [CMP_W-1:0]  del_idx;
    logic [IDX_W-1:0]  rd_idx;
    logic [DATA_W-1:0] rd_data;
    logic              hit;
    logic [FPOS_W-1:0] hit_pos;
    logic [CMP_W-1:0]  list_pos;

    assign out_free  = !out_valid_reg || !out_stall;
    assign cmd_stall = (state_reg != BK_IDLE);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign cnt_ext   = CMP_W'(count_reg);
    assign pos_ext   = {1'b0, cmd_reg.position};
    assign list_pos  = CMP_W'(list_idx_reg) + CMP_W'(1);

    // Resolve the insert slot and its status
    always_comb
    begin
        ins_idx    = '0;
        ins_status = ST_OK;
        priority if (is_full)
        begin
            ins_status = ST_FULL;
        end
        else if (cmd_reg.kind == KIND_INS_FRONT || is_empty)
        begin
            ins_idx = '0;
        end
        else if (cmd_reg.kind == KIND_INS_BACK)
        begin
            ins_idx = cnt_ext;
        end
        else if (cmd_reg.pos_zero)
        begin
            ins_status = ST_BADPOS;
        end
        else if (pos_ext > cnt_ext + CMP_W'(1))
        begin
            ins_status = ST_RANGE;
        end
        else
        begin
            ins_idx = pos_ext - CMP_W'(1);
        end
    end

    // Resolve the delete slot and its status
    always_comb
    begin
        del_idx    = '0;
        del_status = ST_OK;
        priority if (is_empty)
        begin
            del_status = ST_EMPTY;
        end
        else if (cmd_reg.kind == KIND_DEL_FRONT)
        begin
            del_idx = '0;
        end
        else if (cmd_reg.kind == KIND_DEL_BACK)
        begin
            del_idx = cnt_ext - CMP_W'(1);
        end
        else if (cmd_reg.pos_zero)
        begin
            del_status = ST_BADPOS;
        end
        else if (pos_ext > cnt_ext)
        begin
            del_status = ST_RANGE;
        end
        else
        begin
            del_idx = pos_ext - CMP_W'(1);
        end
    end

    // Single read port: the listing cursor or the delete slot
    assign rd_idx  = (state_reg == BK_LIST) ? list_idx_reg : del_idx[IDX_W-1:0];
    assign rd_data = entries_reg[rd_idx];

    // Pick the first registered match
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int j = CAPACITY - 1; j >= 0; j--)
        begin
            if (match_reg[j])
            begin
                hit     = 1'b1;
                hit_pos = FPOS_W'(j + 1);
            end
        end
    end

    // Next state, store update and result beat
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        entries_next    = entries_reg;
        match_next      = match_reg;
        list_idx_next   = list_idx_reg;
        out_valid_next  = out_free ? 1'b0 : out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_fpos_next   = out_fpos_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = BK_EXEC;
                end
            end

            BK_EXEC:
            begin
                if (out_free)
                begin
                    state_next      = BK_IDLE;
                    out_status_next = ST_EMPTY;
                    out_value_next  = '0;
                    out_fpos_next   = '0;
                    out_last_next   = 1'b1;
                    if (cmd_reg.is_insert)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ins_status;
                        if (ins_status == ST_OK)
                        begin
                            // Open a gap at the slot and drop the value in
                            for (int j = 1; j < CAPACITY; j++)
                            begin
                                if (CMP_W'(j) > ins_idx && CMP_W'(j) <= cnt_ext)
                                begin
                                    entries_next[j] = entries_reg[j-1];
                                end
                            end
                            for (int j = 0; j < CAPACITY; j++)
                            begin
                                if (CMP_W'(j) == ins_idx)
                                begin
                                    entries_next[j] = cmd_reg.value;
                                end
                            end
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (cmd_reg.is_delete)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = del_status;
                        if (del_status == ST_OK)
                        begin
                            out_value_next = rd_data;
                            // Close the gap behind the removed slot
                            for (int j = 0; j < CAPACITY - 1; j++)
                            begin
                                if (CMP_W'(j) >= del_idx && CMP_W'(j + 1) < cnt_ext)
                                begin
                                    entries_next[j] = entries_reg[j+1];
                                end
                            end
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    else if (is_empty)
                    begin
                        out_valid_next = 1'b1;
                    end
                    else if (cmd_reg.kind == KIND_SEARCH)
                    begin
                        for (int j = 0; j < CAPACITY; j++)
                        begin
                            match_next[j] = (CMP_W'(j) < cnt_ext)
                                            && (entries_reg[j] == cmd_reg.value);
                        end
                        state_next = BK_SEARCH;
                    end
                    else
                    begin
                        list_idx_next = '0;
                        state_next    = BK_LIST;
                    end
                end
            end

            BK_SEARCH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = hit ? ST_OK : ST_NOTFOUND;
                    out_value_next  = '0;
                    out_fpos_next   = hit_pos;
                    out_last_next   = 1'b1;
                    state_next      = BK_IDLE;
                end
            end

            BK_LIST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_value_next  = rd_data;
                    out_fpos_next   = '0;
                    out_last_next   = (list_pos == cnt_ext);
                    if (list_pos == cnt_ext)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        list_idx_next = list_idx_reg + IDX_W'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        entries_reg    <= entries_next;
        match_reg      <= match_next;
        list_idx_reg   <= list_idx_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_fpos_reg   <= out_fpos_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign result_value   = out_value_reg;
    assign found_position = out_fpos_reg;
    assign last           = out_last_reg;
    assign cnt            = count_reg;

endmodule

[hw/rtl/positional_list_engine.sv]
// Top level of the positional list engine: front, command queue and back.
// Depends on ple_pkg, ple_front, ple_queue and ple_back.
//
//   channel | handshake           | beat fields
//   --------+---------------------+------------------------------------------
//   in      | in_valid / in_stall | kind, value, position
//   out     | out_valid/out_stall | status, result_value, found_position, last
//
// The back registers a command in BK_IDLE; BK_EXEC runs it when the output
// is free, and inserts, deletes and commands finding the list empty end there.
// Search compares in BK_EXEC and picks the first match in BK_SEARCH; BK_LIST
// moves one element per cycle while the output is free, via the single read port.
// Reset clears the element count; the store itself needs no clearing pass.
// The front register and a two-entry queue keep taking beats while the
// back waits on a stalled output register.
module positional_list_engine import ple_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [KIND_W-1:0]        kind,
    input  logic signed [DATA_W-1:0] value,
    input  logic [POS_W-1:0]         position,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic signed [DATA_W-1:0] result_value,
    output logic [FPOS_W-1:0]        found_position,
    output logic                     last
);

    logic             f_valid;
    logic             f_stall;
    cmd_t             f_cmd;
    logic             q_valid;
    logic             q_stall;
    cmd_t             q_cmd;
    logic [CNT_W-1:0] cnt;

    ple_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .value     (value),
        .position  (position),
        .cmd_valid (f_valid),
        .cmd_stall (f_stall),
        .cmd       (f_cmd)
    );

    ple_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_stall (f_stall),
        .push_data  (f_cmd),
        .pop_valid  (q_valid),
        .pop_stall  (q_stall),
        .pop_data   (q_cmd)
    );

    ple_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (q_valid),
        .cmd_stall      (q_stall),
        .cmd            (q_cmd),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .result_value   (result_value),
        .found_position (found_position),
        .last           (last),
        .cnt            (cnt)
    );

    // The element count never passes the capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // The count moves by one at most
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt != $past(cnt)) |->
            (cnt == $past(cnt) + CNT_W'(1)) || (cnt + CNT_W'(1) == $past(cnt)))
        else $error("element count jumped");

    // A change of the count comes with its result beat
    a_cnt_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt != $past(cnt)) |-> out_valid)
        else $error("element count changed without a result beat");

endmodule

[sim/positional_list_engine_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the positional list engine.
// Depends on ple_pkg and positional_list_engine; needs no files or arguments.
module positional_list_engine_tb;

    import ple_pkg::*;

    // One result beat as it should leave the engine
    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   value;
        logic [FPOS_W-1:0]   fpos;
        logic                last;
    } beat_t;

    // One directed command; the typed status applies only where typed is set
    typedef struct packed {
        kind_t               kind;
        logic [DATA_W-1:0]   value;
        logic [POS_W-1:0]    position;
        logic                typed;
        status_t             status;
    } row_t;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } mix_t;

    // Directed commands, walked in order right after reset
    localparam int DIRECTED_N = 24;
    localparam row_t DIRECTED_ROWS [0:DIRECTED_N-1] = '{
        '{KIND_DEL_FRONT, 32'h0000_0000, 8'd0,   1'b1, ST_EMPTY},
        '{KIND_DEL_BACK,  32'h0000_0000, 8'd0,   1'b1, ST_EMPTY},
        '{KIND_DEL_AT,    32'h0000_0000, 8'd0,   1'b1, ST_EMPTY},
        '{KIND_SEARCH,    32'h0000_0005, 8'd1,   1'b1, ST_EMPTY},
        '{KIND_LIST_ALL,  32'h0000_0000, 8'd0,   1'b1, ST_EMPTY},
        '{KIND_INS_AT,    32'h0000_0005, 8'd200, 1'b1, ST_OK},
        '{KIND_INS_FRONT, 32'h8000_0000, 8'd0,   1'b1, ST_OK},
        '{KIND_INS_BACK,  32'h7FFF_FFFF, 8'd0,   1'b1, ST_OK},
        '{KIND_INS_AT,    32'h0000_0009, 8'd0,   1'b1, ST_BADPOS},
        '{KIND_INS_AT,    32'h0000_0009, 8'd5,   1'b1, ST_RANGE},
        '{KIND_INS_AT,    32'hFFFF_FFFF, 8'd4,   1'b1, ST_OK},
        '{KIND_INS_AT,    32'h0000_0009, 8'd255, 1'b1, ST_RANGE},
        '{KIND_DEL_AT,    32'h0000_0000, 8'd0,   1'b1, ST_BADPOS},
        '{KIND_DEL_AT,    32'h0000_0000, 8'd5,   1'b1, ST_RANGE},
        '{KIND_SEARCH,    32'h7FFF_FFFF, 8'd0,   1'b0, ST_OK},
        '{KIND_SEARCH,    32'h0000_3039, 8'd0,   1'b1, ST_NOTFOUND},
        '{KIND_INS_AT,    32'h0000_0005, 8'd1,   1'b0, ST_OK},
        '{KIND_SEARCH,    32'h0000_0005, 8'd0,   1'b0, ST_OK},
        '{KIND_LIST_ALL,  32'h0000_0000, 8'd0,   1'b0, ST_OK},
        '{KIND_DEL_AT,    32'h0000_0000, 8'd2,   1'b0, ST_OK},
        '{KIND_DEL_FRONT, 32'h0000_0000, 8'd0,   1'b0, ST_OK},
        '{KIND_DEL_BACK,  32'h0000_0000, 8'd0,   1'b0, ST_OK},
        '{KIND_DEL_AT,    32'h0000_0000, 8'd2,   1'b0, ST_OK},
        '{KIND_LIST_ALL,  32'h0000_0000, 8'd0,   1'b0, ST_OK}
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [KIND_W-1:0]         kind = '0;
    logic signed [DATA_W-1:0]  value = '0;
    logic [POS_W-1:0]          position = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic signed [DATA_W-1:0]  result_value;
    logic [FPOS_W-1:0]         found_position;
    logic                      last;

    // Shadow copy of the list and the beats still owed by the engine
    logic signed [DATA_W-1:0]  list_store [CAPACITY];
    int                        list_len = 0;
    beat_t                     pending_beats [$];

    int                        mismatch_count = 0;
    int                        gap_pct = 0;
    int                        stall_pct = 0;
    int                        stall_left = 0;

    positional_list_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .value          (value),
        .position       (position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .result_value   (result_value),
        .found_position (found_position),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the shadow list; queue its beats when record is set
    task automatic predict_list_op(input kind_t k, input logic signed [DATA_W-1:0] v,
                                   input logic [POS_W-1:0] p, input bit record);
        int    i;
        int    slot;
        beat_t b;
        b = beat_t'{ST_OK, '0, '0, 1'b1};
        case (k)
            KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT:
            begin
                if (list_len >= CAPACITY)
                    b.status = ST_FULL;
                else if (k == KIND_INS_AT && list_len != 0 && p == 0)
                    b.status = ST_BADPOS;
                else if (k == KIND_INS_AT && list_len != 0 && p > list_len + 1)
                    b.status = ST_RANGE;
                else
                begin
                    if (k == KIND_INS_BACK)
                        slot = list_len;
                    else if (k == KIND_INS_AT && list_len != 0)
                        slot = p - 1;
                    else
                        slot = 0;
                    for (i = list_len; i > slot; i--)
                        list_store[i] = list_store[i-1];
                    list_store[slot] = v;
                    list_len++;
                end
            end
            KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AT:
            begin
                if (list_len == 0)
                    b.status = ST_EMPTY;
                else if (k == KIND_DEL_AT && p == 0)
                    b.status = ST_BADPOS;
                else if (k == KIND_DEL_AT && p > list_len)
                    b.status = ST_RANGE;
                else
                begin
                    if (k == KIND_DEL_FRONT)
                        slot = 0;
                    else if (k == KIND_DEL_BACK)
                        slot = list_len - 1;
                    else
                        slot = p - 1;
                    b.value = list_store[slot];
                    for (i = slot; i + 1 < list_len; i++)
                        list_store[i] = list_store[i+1];
                    list_len--;
                end
            end
            KIND_SEARCH:
            begin
                if (list_len == 0)
                    b.status = ST_EMPTY;
                else
                begin
                    b.status = ST_NOTFOUND;
                    for (i = list_len - 1; i >= 0; i--)
                        if (list_store[i] == v)
                        begin
                            b.status = ST_OK;
                            b.fpos   = FPOS_W'(i + 1);
                        end
                end
            end
            default:
            begin
                if (list_len == 0)
                    b.status = ST_EMPTY;
                else
                begin
                    // Emit every element in order, marking the final one
                    if (record)
                        for (i = 0; i < list_len; i++)
                            pending_beats.push_back(beat_t'{ST_OK, list_store[i], '0,
                                                            (i + 1 == list_len)});
                    return;
                end
            end
        endcase
        if (record)
            pending_beats.push_back(b);
    endtask

    // Send one command beat and record what it should produce once accepted
    task automatic send_command(input kind_t k, input logic [DATA_W-1:0] v,
                                input logic [POS_W-1:0] p, input bit typed,
                                input status_t typed_status);
        int gap;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_list_op(k, v, p, !typed);
        if (typed)
            pending_beats.push_back(beat_t'{typed_status, '0, '0, 1'b1});
    endtask

    // Drop valid and hold until every owed beat has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    // Random commands, weighted toward filling, emptying or neither
    task automatic run_phase(input mix_t mix, input int items, input int gap, input int stall);
        int                 n;
        int                 r;
        kind_t              k;
        logic [DATA_W-1:0]  v;
        logic [POS_W-1:0]   p;
        gap_pct   = gap;
        stall_pct = stall;
        for (n = 0; n < items; n++)
        begin
            r = $urandom_range(0, 99);
            case (mix)
                MIX_GROW:
                    if (r < 80)      k = kind_t'($urandom_range(0, 2));
                    else if (r < 90) k = KIND_SEARCH;
                    else if (r < 95) k = KIND_LIST_ALL;
                    else             k = kind_t'($urandom_range(3, 5));
                MIX_SHRINK:
                    if (r < 70)      k = kind_t'($urandom_range(3, 5));
                    else if (r < 85) k = KIND_SEARCH;
                    else if (r < 95) k = KIND_LIST_ALL;
                    else             k = kind_t'($urandom_range(0, 2));
                default:
                    k = kind_t'($urandom_range(0, 7));
            endcase

            // Favor values already in the list and small values for duplicates
            r = $urandom_range(0, 2);
            if (r == 0 && list_len > 0)
                v = list_store[$urandom_range(0, list_len - 1)];
            else if (r == 1)
                v = $urandom_range(0, 7);
            else
                v = $urandom;

            // Mostly legal positions, some zero, some anywhere in the field
            r = $urandom_range(0, 99);
            if (r < 10)
                p = '0;
            else if (r < 30)
                p = POS_W'($urandom_range(0, 255));
            else if (k == KIND_INS_AT)
                p = POS_W'($urandom_range(1, list_len + 1));
            else
                p = POS_W'($urandom_range(1, (list_len > 0) ? list_len : 1));

            send_command(k, v, p, 1'b0, ST_OK);
        end
    endtask

    // Stall the output in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each accepted result beat with the oldest owed beat
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected beat: status %0d result_value %h found_position %0d",
                       status, result_value, found_position);
                mismatch_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    mismatch_count++;
                end
                if (result_value !== want.value)
                begin
                    $error("result_value: expected %h, actual %h", want.value, result_value);
                    mismatch_count++;
                end
                if (found_position !== want.fpos)
                begin
                    $error("found_position: expected %0d, actual %0d",
                           want.fpos, found_position);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int row;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed commands with light idling on both sides
        gap_pct   = 25;
        stall_pct = 25;
        for (row = 0; row < DIRECTED_N; row++)
            send_command(DIRECTED_ROWS[row].kind, DIRECTED_ROWS[row].value,
                         DIRECTED_ROWS[row].position, DIRECTED_ROWS[row].typed,
                         DIRECTED_ROWS[row].status);
        drain_results();

        // Random commands: fill to full, churn, empty out, and again
        run_phase(MIX_GROW,   60, 20, 20);
        run_phase(MIX_EVEN,   80,  0, 30);
        drain_results();
        run_phase(MIX_SHRINK, 60, 30,  0);
        run_phase(MIX_GROW,   50, 15, 15);
        run_phase(MIX_EVEN,   70, 25, 25);
        run_phase(MIX_SHRINK, 40, 10, 40);
        drain_results();
        run_phase(MIX_EVEN,   40,  0,  0);

        // Let any stray beats surface before the verdict
        drain_results();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Give up if the engine hangs
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
